[hw/rtl/cfr_pkg.sv]
// Shared types, opcodes and helpers for the x86 control-flow resolver.
`default_nettype none

package cfr_pkg;

  // Opcode bytes
  localparam logic [7:0] OP_JCC_SHORT_LO = 8'h70;
  localparam logic [7:0] OP_JCC_SHORT_HI = 8'h7f;
  localparam logic [7:0] OP_ESCAPE       = 8'h0f;
  localparam logic [7:0] OP_JCC_NEAR_LO  = 8'h80;
  localparam logic [7:0] OP_JCC_NEAR_HI  = 8'h8f;
  localparam logic [7:0] OP_RDTSC        = 8'h31;
  localparam logic [7:0] OP_JMP_SHORT    = 8'heb;
  localparam logic [7:0] OP_JMP_NEAR     = 8'he9;
  localparam logic [7:0] OP_CALL_NEAR    = 8'he8;
  localparam logic [7:0] OP_RET          = 8'hc3;
  localparam logic [7:0] OP_REPZ         = 8'hf3;
  localparam logic [7:0] OP_GRP5         = 8'hff;
  localparam logic [7:0] OP_OUT_B        = 8'he6;
  localparam logic [7:0] OP_OUT_W        = 8'he7;

  // ModRM reg field of group 5
  localparam logic [2:0] GRP5_CALL = 3'd2;
  localparam logic [2:0] GRP5_JMP  = 3'd4;

  // ModRM mode field
  localparam logic [1:0] MOD_IND    = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  // ModRM r/m field
  typedef enum logic [2:0] {
    RM_A   = 3'd0,
    RM_C   = 3'd1,
    RM_D   = 3'd2,
    RM_B   = 3'd3,
    RM_SIB = 3'd4,
    RM_BP  = 3'd5,
    RM_SI  = 3'd6,
    RM_DI  = 3'd7
  } rm_e;

  // Instruction lengths
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_5 = 3'd5;
  localparam logic [2:0] LEN_6 = 3'd6;

  // Condition pairs, low bit of the code inverts
  typedef enum logic [2:0] {
    CC_O  = 3'd0,
    CC_B  = 3'd1,
    CC_Z  = 3'd2,
    CC_BE = 3'd3,
    CC_S  = 3'd4,
    CC_P  = 3'd5,
    CC_L  = 3'd6,
    CC_LE = 3'd7
  } cc_e;

  // Flag bit positions
  localparam int unsigned FL_CF = 0;
  localparam int unsigned FL_PF = 2;
  localparam int unsigned FL_ZF = 6;
  localparam int unsigned FL_SF = 7;
  localparam int unsigned FL_OF = 11;

  typedef enum logic [1:0] {
    ESP_KEEP = 2'd0,
    ESP_DEC  = 2'd1,
    ESP_INC  = 2'd2
  } esp_op_e;

  // Input beat
  typedef struct packed {
    logic [31:0] pc;
    logic [47:0] instr_bytes;
    logic [11:0] flags;
    logic [31:0] reg_a;
    logic [31:0] reg_c;
    logic [31:0] reg_d;
    logic [31:0] reg_b;
    logic [31:0] reg_bp;
    logic [31:0] reg_si;
    logic [31:0] reg_di;
    logic [31:0] reg_sp;
    logic [63:0] retired_count;
  } in_t;

  // Decode to execute
  typedef struct packed {
    logic        ok;
    logic        from_load;
    logic        push;
    logic        rdtsc;
    logic        marker;
    esp_op_e     esp_op;
    logic [7:0]  marker_value;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] ret_addr;
    logic [31:0] rsp;
    logic [63:0] count;
  } dec_t;

  // Execute to result
  typedef struct packed {
    logic        ok;
    logic        from_load;
    logic        push;
    logic        rdtsc;
    logic        marker;
    logic [7:0]  marker_value;
    logic [31:0] sum;
    logic [31:0] new_esp;
    logic [31:0] ret_addr;
    logic [63:0] count;
  } exe_t;

  // Result beat
  typedef struct packed {
    logic        handled;
    logic [31:0] next_pc;
    logic        target_from_load;
    logic [31:0] load_addr;
    logic        push_return;
    logic [31:0] new_esp;
    logic [31:0] return_addr;
    logic        rdtsc_valid;
    logic [31:0] count_low;
    logic [31:0] count_high;
    logic        marker_valid;
    logic [7:0]  marker_value;
  } res_t;

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic logic cond_true(input logic [3:0] cc, input logic [11:0] fl);
    logic lt;
    logic r;
    lt = fl[FL_SF] ^ fl[FL_OF];
    unique case (cc_e'(cc[3:1]))
      CC_O:    r = fl[FL_OF];
      CC_B:    r = fl[FL_CF];
      CC_Z:    r = fl[FL_ZF];
      CC_BE:   r = fl[FL_CF] | fl[FL_ZF];
      CC_S:    r = fl[FL_SF];
      CC_P:    r = fl[FL_PF];
      CC_L:    r = lt;
      CC_LE:   r = fl[FL_ZF] | lt;
      default: r = 1'b0;
    endcase
    return r ^ cc[0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cfr_decode.sv]
// Stage 1: opcode decode, condition check, operand select and pc + length.
`default_nettype none

module cfr_decode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire cfr_pkg::in_t  data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output cfr_pkg::dec_t      data_o
);
  import cfr_pkg::*;

  logic [7:0]  b0, b1, b2;
  logic [31:0] w1, w2;
  logic [1:0]  mode;
  logic [2:0]  grp_op;
  logic [31:0] base;
  logic        base_ok;
  logic [2:0]  len;
  logic [31:0] pc_len;
  dec_t        dec_d, dec_q;
  logic        valid_q;

  assign b0     = data_i.instr_bytes[7:0];
  assign b1     = data_i.instr_bytes[15:8];
  assign b2     = data_i.instr_bytes[23:16];
  assign w1     = data_i.instr_bytes[39:8];
  assign w2     = data_i.instr_bytes[47:16];
  assign mode   = b1[7:6];
  assign grp_op = b1[5:3];

  // Group 5 base register
  always_comb begin
    base_ok = 1'b1;
    unique case (rm_e'(b1[2:0]))
      RM_A:    base = data_i.reg_a;
      RM_C:    base = data_i.reg_c;
      RM_D:    base = data_i.reg_d;
      RM_B:    base = data_i.reg_b;
      RM_BP:   base = (mode == MOD_IND) ? w2 : data_i.reg_bp;
      RM_SI:   base = data_i.reg_si;
      RM_DI:   base = data_i.reg_di;
      default: begin
        base    = '0;
        base_ok = 1'b0;
      end
    endcase
  end

  // Instruction length
  always_comb begin
    priority if (b0 == OP_ESCAPE) begin
      len = (b1 >= OP_JCC_NEAR_LO && b1 <= OP_JCC_NEAR_HI) ? LEN_6 : LEN_2;
    end else if (b0 == OP_JMP_NEAR || b0 == OP_CALL_NEAR) begin
      len = LEN_5;
    end else if (b0 == OP_GRP5) begin
      unique case (mode)
        MOD_IND:    len = (rm_e'(b1[2:0]) == RM_BP) ? LEN_6 : LEN_2;
        MOD_DISP8:  len = LEN_3;
        MOD_DISP32: len = LEN_6;
        default:    len = LEN_2;
      endcase
    end else begin
      len = LEN_2;
    end
  end

  assign pc_len = data_i.pc + {29'd0, len};

  // Operand select per opcode
  always_comb begin
    dec_d              = '0;
    dec_d.ok           = 1'b1;
    dec_d.esp_op       = ESP_KEEP;
    dec_d.rsp          = data_i.reg_sp;
    dec_d.count        = data_i.retired_count;
    dec_d.add_a        = pc_len;
    priority if (b0 >= OP_JCC_SHORT_LO && b0 <= OP_JCC_SHORT_HI) begin
      dec_d.add_b = cond_true(b0[3:0], data_i.flags) ? sext8(b1) : '0;
    end else if (b0 == OP_JMP_SHORT) begin
      dec_d.add_b = sext8(b1);
    end else if (b0 == OP_OUT_B || b0 == OP_OUT_W) begin
      dec_d.marker       = 1'b1;
      dec_d.marker_value = b1;
    end else if (b0 == OP_ESCAPE) begin
      priority if (b1 >= OP_JCC_NEAR_LO && b1 <= OP_JCC_NEAR_HI) begin
        dec_d.add_b = cond_true(b1[3:0], data_i.flags) ? w2 : '0;
      end else if (b1 == OP_RDTSC) begin
        dec_d.rdtsc = 1'b1;
      end else begin
        dec_d.ok = 1'b0;
      end
    end else if (b0 == OP_JMP_NEAR) begin
      dec_d.add_b = w1;
    end else if (b0 == OP_CALL_NEAR) begin
      dec_d.add_b    = w1;
      dec_d.push     = 1'b1;
      dec_d.ret_addr = pc_len;
      dec_d.esp_op   = ESP_DEC;
    end else if (b0 == OP_RET || (b0 == OP_REPZ && b1 == OP_RET)) begin
      dec_d.from_load = 1'b1;
      dec_d.add_a     = data_i.reg_sp;
      dec_d.esp_op    = ESP_INC;
    end else if (b0 == OP_GRP5) begin
      dec_d.ok        = base_ok && (grp_op == GRP5_CALL || grp_op == GRP5_JMP);
      dec_d.add_a     = base;
      dec_d.from_load = (mode != MOD_REG);
      unique case (mode)
        MOD_DISP8:  dec_d.add_b = sext8(b2);
        MOD_DISP32: dec_d.add_b = w2;
        default:    dec_d.add_b = '0;
      endcase
      if (grp_op == GRP5_CALL) begin
        dec_d.push     = 1'b1;
        dec_d.ret_addr = pc_len;
        dec_d.esp_op   = ESP_DEC;
      end
    end else begin
      dec_d.ok = 1'b0;
    end
  end

  // Stage register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = dec_q;

endmodule

`default_nettype wire

[hw/rtl/cfr_exec.sv]
// Stage 2: target/effective-address add and stack pointer update.
`default_nettype none

module cfr_exec (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire cfr_pkg::dec_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output cfr_pkg::exe_t      data_o
);
  import cfr_pkg::*;

  exe_t exe_d, exe_q;
  logic valid_q;

  always_comb begin
    exe_d.ok           = data_i.ok;
    exe_d.from_load    = data_i.from_load;
    exe_d.push         = data_i.push;
    exe_d.rdtsc        = data_i.rdtsc;
    exe_d.marker       = data_i.marker;
    exe_d.marker_value = data_i.marker_value;
    exe_d.ret_addr     = data_i.ret_addr;
    exe_d.count        = data_i.count;
    exe_d.sum          = data_i.add_a + data_i.add_b;
    unique case (data_i.esp_op)
      ESP_DEC: exe_d.new_esp = data_i.rsp - 32'd4;
      ESP_INC: exe_d.new_esp = data_i.rsp + 32'd4;
      default: exe_d.new_esp = data_i.rsp;
    endcase
  end

  // Stage register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      exe_q <= exe_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = exe_q;

endmodule

`default_nettype wire

[hw/rtl/cfr_result.sv]
// Stage 3: result formatting and output register.
`default_nettype none

module cfr_result (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire cfr_pkg::exe_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output cfr_pkg::res_t      data_o
);
  import cfr_pkg::*;

  res_t res_d, res_q;
  logic valid_q;

  // Unhandled opcodes give an all-zero beat
  always_comb begin
    res_d = '0;
    if (data_i.ok) begin
      res_d.handled          = 1'b1;
      res_d.next_pc          = data_i.from_load ? '0 : data_i.sum;
      res_d.target_from_load = data_i.from_load;
      res_d.load_addr        = data_i.from_load ? data_i.sum : '0;
      res_d.push_return      = data_i.push;
      res_d.new_esp          = data_i.new_esp;
      res_d.return_addr      = data_i.ret_addr;
      res_d.rdtsc_valid      = data_i.rdtsc;
      res_d.count_low        = data_i.rdtsc ? data_i.count[31:0] : '0;
      res_d.count_high       = data_i.rdtsc ? data_i.count[63:32] : '0;
      res_d.marker_valid     = data_i.marker;
      res_d.marker_value     = data_i.marker_value;
    end
  end

  // Output register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = res_q;

endmodule

`default_nettype wire

[hw/rtl/x86_control_flow_resolver.sv]
// Top level: x86 control-flow resolver, three-stage pipeline.
// A beat passes through the decode, add and output registers in that order.
// Throughput: one instruction per cycle while out_ready_i is high; each stage holds one beat and moves
// whenever the stage after it is empty or draining, so a stall loses nothing.
// Reset: rst_ni clears all stage valid bits; no other state is reset.
`default_nettype none

module x86_control_flow_resolver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] pc_i,
  input  wire logic [47:0] instr_bytes_i,
  input  wire logic [11:0] flags_i,
  input  wire logic [31:0] reg_a_i,
  input  wire logic [31:0] reg_c_i,
  input  wire logic [31:0] reg_d_i,
  input  wire logic [31:0] reg_b_i,
  input  wire logic [31:0] reg_bp_i,
  input  wire logic [31:0] reg_si_i,
  input  wire logic [31:0] reg_di_i,
  input  wire logic [31:0] reg_sp_i,
  input  wire logic [63:0] retired_count_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             handled_o,
  output logic [31:0]      next_pc_o,
  output logic             target_from_load_o,
  output logic [31:0]      load_addr_o,
  output logic             push_return_o,
  output logic [31:0]      new_esp_o,
  output logic [31:0]      return_addr_o,
  output logic             rdtsc_valid_o,
  output logic [31:0]      count_low_o,
  output logic [31:0]      count_high_o,
  output logic             marker_valid_o,
  output logic [7:0]       marker_value_o
);
  import cfr_pkg::*;

  in_t  in_beat;
  dec_t dec_beat;
  exe_t exe_beat;
  res_t res_beat;
  logic dec_valid, dec_ready;
  logic exe_valid, exe_ready;

  assign in_beat.pc            = pc_i;
  assign in_beat.instr_bytes   = instr_bytes_i;
  assign in_beat.flags         = flags_i;
  assign in_beat.reg_a         = reg_a_i;
  assign in_beat.reg_c         = reg_c_i;
  assign in_beat.reg_d         = reg_d_i;
  assign in_beat.reg_b         = reg_b_i;
  assign in_beat.reg_bp        = reg_bp_i;
  assign in_beat.reg_si        = reg_si_i;
  assign in_beat.reg_di        = reg_di_i;
  assign in_beat.reg_sp        = reg_sp_i;
  assign in_beat.retired_count = retired_count_i;

  cfr_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_beat),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .data_o  (dec_beat)
  );

  cfr_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec_beat),
    .valid_o (exe_valid),
    .ready_i (exe_ready),
    .data_o  (exe_beat)
  );

  cfr_result u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (exe_valid),
    .ready_o (exe_ready),
    .data_i  (exe_beat),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_beat)
  );

  assign handled_o          = res_beat.handled;
  assign next_pc_o          = res_beat.next_pc;
  assign target_from_load_o = res_beat.target_from_load;
  assign load_addr_o        = res_beat.load_addr;
  assign push_return_o      = res_beat.push_return;
  assign new_esp_o          = res_beat.new_esp;
  assign return_addr_o      = res_beat.return_addr;
  assign rdtsc_valid_o      = res_beat.rdtsc_valid;
  assign count_low_o        = res_beat.count_low;
  assign count_high_o       = res_beat.count_high;
  assign marker_valid_o     = res_beat.marker_valid;
  assign marker_value_o     = res_beat.marker_value;

endmodule

`default_nettype wire

[tb/x86_control_flow_resolver_test.sv]
// Self-checking testbench for the x86 control-flow resolver.
`timescale 1ns / 1ps

module x86_control_flow_resolver_test;
  import cfr_pkg::*;

  localparam int unsigned NUM_RANDOM = 1000;
  localparam int unsigned IDLE_PCT   = 27;
  // No idling on either side inside this window of cycles
  localparam int unsigned BURST_LO   = 300;
  localparam int unsigned BURST_HI   = 800;
  localparam int unsigned DRAIN_CYC  = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Input side
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  cur_instr = '0;

  // Result side
  logic out_valid;
  logic out_ready = 1'b0;
  res_t got_res;

  in_t  instr_q[$];      // instructions waiting to be driven
  res_t resolved_q[$];   // resolutions expected, oldest first

  int unsigned cyc_cnt;
  int unsigned n_errors;
  int unsigned n_issued;
  int unsigned n_checked;
  int unsigned n_handled;
  int unsigned n_loads;
  int unsigned n_pushes;

  x86_control_flow_resolver dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .pc_i              (cur_instr.pc),
    .instr_bytes_i     (cur_instr.instr_bytes),
    .flags_i           (cur_instr.flags),
    .reg_a_i           (cur_instr.reg_a),
    .reg_c_i           (cur_instr.reg_c),
    .reg_d_i           (cur_instr.reg_d),
    .reg_b_i           (cur_instr.reg_b),
    .reg_bp_i          (cur_instr.reg_bp),
    .reg_si_i          (cur_instr.reg_si),
    .reg_di_i          (cur_instr.reg_di),
    .reg_sp_i          (cur_instr.reg_sp),
    .retired_count_i   (cur_instr.retired_count),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .handled_o         (got_res.handled),
    .next_pc_o         (got_res.next_pc),
    .target_from_load_o(got_res.target_from_load),
    .load_addr_o       (got_res.load_addr),
    .push_return_o     (got_res.push_return),
    .new_esp_o         (got_res.new_esp),
    .return_addr_o     (got_res.return_addr),
    .rdtsc_valid_o     (got_res.rdtsc_valid),
    .count_low_o       (got_res.count_low),
    .count_high_o      (got_res.count_high),
    .marker_valid_o    (got_res.marker_valid),
    .marker_value_o    (got_res.marker_value)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Condition code evaluation: pair in bits 3..1, bit 0 inverts
  function automatic logic jcc_taken(input logic [3:0] cc, input logic [11:0] fl);
    logic lt;
    logic hit;
    lt = fl[FL_SF] != fl[FL_OF];
    case (cc_e'(cc[3:1]))
      CC_O:    hit = fl[FL_OF];
      CC_B:    hit = fl[FL_CF];
      CC_Z:    hit = fl[FL_ZF];
      CC_BE:   hit = fl[FL_CF] || fl[FL_ZF];
      CC_S:    hit = fl[FL_SF];
      CC_P:    hit = fl[FL_PF];
      CC_L:    hit = lt;
      default: hit = fl[FL_ZF] || lt;
    endcase
    return hit ^ cc[0];
  endfunction

  // Expected resolution of one instruction
  function automatic res_t resolve_branch(input in_t it);
    res_t        r;
    logic        ok, from_load, push, rdtsc, marker, mem;
    logic [7:0]  b0, b1, d8;
    logic [31:0] nxt_pc, laddr, esp, ret_pc, base, w1, w2;
    logic [1:0]  mode;
    logic [2:0]  op, rmf;
    logic [31:0] len;
    b0 = it.instr_bytes[7:0];
    b1 = it.instr_bytes[15:8];
    d8 = it.instr_bytes[23:16];
    w1 = it.instr_bytes[39:8];
    w2 = it.instr_bytes[47:16];
    ok = 1'b1;
    from_load = 1'b0;
    push = 1'b0;
    rdtsc = 1'b0;
    marker = 1'b0;
    nxt_pc = '0;
    laddr = '0;
    ret_pc = '0;
    esp = it.reg_sp;
    if (b0 >= OP_JCC_SHORT_LO && b0 <= OP_JCC_SHORT_HI) begin
      nxt_pc = it.pc + 32'd2;
      if (jcc_taken(b0[3:0], it.flags)) nxt_pc = nxt_pc + {{24{b1[7]}}, b1};
    end else if (b0 == OP_JMP_SHORT) begin
      nxt_pc = it.pc + 32'd2 + {{24{b1[7]}}, b1};
    end else if (b0 == OP_OUT_B || b0 == OP_OUT_W) begin
      nxt_pc = it.pc + 32'd2;
      marker = 1'b1;
    end else if (b0 == OP_ESCAPE) begin
      if (b1 >= OP_JCC_NEAR_LO && b1 <= OP_JCC_NEAR_HI) begin
        nxt_pc = it.pc + 32'd6;
        if (jcc_taken(b1[3:0], it.flags)) nxt_pc = nxt_pc + w2;
      end else if (b1 == OP_RDTSC) begin
        nxt_pc = it.pc + 32'd2;
        rdtsc = 1'b1;
      end else begin
        ok = 1'b0;
      end
    end else if (b0 == OP_JMP_NEAR) begin
      nxt_pc = it.pc + 32'd5 + w1;
    end else if (b0 == OP_CALL_NEAR) begin
      ret_pc = it.pc + 32'd5;
      esp = it.reg_sp - 32'd4;
      push = 1'b1;
      nxt_pc = ret_pc + w1;
    end else if (b0 == OP_RET || (b0 == OP_REPZ && b1 == OP_RET)) begin
      from_load = 1'b1;
      laddr = it.reg_sp;
      esp = it.reg_sp + 32'd4;
    end else if (b0 == OP_GRP5) begin
      mode = b1[7:6];
      op = b1[5:3];
      rmf = b1[2:0];
      base = '0;
      case (rm_e'(rmf))
        RM_A:    base = it.reg_a;
        RM_C:    base = it.reg_c;
        RM_D:    base = it.reg_d;
        RM_B:    base = it.reg_b;
        RM_BP:   base = (mode == MOD_IND) ? w2 : it.reg_bp;
        RM_SI:   base = it.reg_si;
        RM_DI:   base = it.reg_di;
        default: ok = 1'b0;   // SIB form, not supported
      endcase
      if (op != GRP5_CALL && op != GRP5_JMP) ok = 1'b0;
      if (ok) begin
        mem = 1'b1;
        laddr = base;
        len = 32'd2;
        case (mode)
          MOD_IND: len = (rm_e'(rmf) == RM_BP) ? 32'd6 : 32'd2;
          MOD_DISP8: begin
            laddr = base + {{24{d8[7]}}, d8};
            len = 32'd3;
          end
          MOD_DISP32: begin
            laddr = base + w2;
            len = 32'd6;
          end
          default: begin
            mem = 1'b0;
            laddr = '0;
            nxt_pc = base;
          end
        endcase
        from_load = mem;
        if (op == GRP5_CALL) begin
          ret_pc = it.pc + len;
          esp = it.reg_sp - 32'd4;
          push = 1'b1;
        end
      end
    end else begin
      ok = 1'b0;
    end

    r = '0;
    if (ok) begin
      r.handled = 1'b1;
      r.next_pc = from_load ? 32'd0 : nxt_pc;
      r.target_from_load = from_load;
      r.load_addr = laddr;
      r.push_return = push;
      r.new_esp = esp;
      r.return_addr = ret_pc;
      r.rdtsc_valid = rdtsc;
      r.count_low = rdtsc ? it.retired_count[31:0] : 32'd0;
      r.count_high = rdtsc ? it.retired_count[63:32] : 32'd0;
      r.marker_valid = marker;
      r.marker_value = marker ? b1 : 8'd0;
    end
    return r;
  endfunction

  function automatic logic idle_now();
    if (cyc_cnt >= BURST_LO && cyc_cnt < BURST_HI) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // Instruction with the given address and bytes, everything else random
  function automatic in_t rand_instr(input logic [31:0] pc, input logic [47:0] ib);
    in_t it;
    it.pc = pc;
    it.instr_bytes = ib;
    it.flags = 12'($urandom);
    it.reg_a = $urandom;
    it.reg_c = $urandom;
    it.reg_d = $urandom;
    it.reg_b = $urandom;
    it.reg_bp = $urandom;
    it.reg_si = $urandom;
    it.reg_di = $urandom;
    it.reg_sp = $urandom;
    it.retired_count = {$urandom, $urandom};
    return it;
  endfunction

  // Random instruction, mostly of a supported shape
  function automatic in_t gen_instr();
    logic [47:0] ib;
    logic [7:0]  b0, b1;
    logic [2:0]  op;
    ib = 48'({$urandom, $urandom});
    b0 = ib[7:0];
    b1 = ib[15:8];
    case ($urandom_range(15))
      0, 1: b0 = {OP_JCC_SHORT_LO[7:4], b0[3:0]};
      2:    b0 = OP_JMP_SHORT;
      3:    b0 = b0[0] ? OP_OUT_W : OP_OUT_B;
      4, 5: begin
        b0 = OP_ESCAPE;
        b1 = {OP_JCC_NEAR_LO[7:4], b1[3:0]};
      end
      6: begin
        b0 = OP_ESCAPE;
        if (b1[7]) b1 = OP_RDTSC;
      end
      7: b0 = OP_JMP_NEAR;
      8: b0 = OP_CALL_NEAR;
      9: b0 = OP_RET;
      10: begin
        b0 = OP_REPZ;
        if ($urandom_range(3) != 0) b1 = OP_RET;
      end
      11, 12, 13, 14: begin
        b0 = OP_GRP5;
        op = b1[5:3];
        if ($urandom_range(9) < 8) op = b1[0] ? GRP5_CALL : GRP5_JMP;
        b1 = {b1[7:6], op, b1[2:0]};
      end
      default: ;
    endcase
    ib[15:0] = {b1, b0};
    return rand_instr($urandom, ib);
  endfunction

  // Driver: hold a beat until it is taken, then move on to the next one
  always @(posedge clk_i) begin : drive
    in_t  nxt_instr;
    logic nxt_valid;
    if (rst_ni) begin
      nxt_instr = cur_instr;
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        resolved_q.push_back(resolve_branch(cur_instr));
        n_issued++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && instr_q.size() != 0 && !idle_now()) begin
        nxt_instr = instr_q.pop_front();
        nxt_valid = 1'b1;
      end
      cur_instr <= nxt_instr;
      in_valid <= nxt_valid;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : collect
    res_t want;
    if (rst_ni) begin
      cyc_cnt++;
      if (out_valid && out_ready) begin
        if (resolved_q.size() == 0) begin
          $error("result beat with no instruction outstanding");
          n_errors++;
        end else begin
          want = resolved_q.pop_front();
          n_checked++;
          n_handled += want.handled;
          n_loads += want.target_from_load;
          n_pushes += want.push_return;
          check_field("handled", want.handled, got_res.handled);
          check_field("next_pc", want.next_pc, got_res.next_pc);
          check_field("target_from_load", want.target_from_load,
                      got_res.target_from_load);
          check_field("load_addr", want.load_addr, got_res.load_addr);
          check_field("push_return", want.push_return, got_res.push_return);
          check_field("new_esp", want.new_esp, got_res.new_esp);
          check_field("return_addr", want.return_addr, got_res.return_addr);
          check_field("rdtsc_valid", want.rdtsc_valid, got_res.rdtsc_valid);
          check_field("count_low", want.count_low, got_res.count_low);
          check_field("count_high", want.count_high, got_res.count_high);
          check_field("marker_valid", want.marker_valid, got_res.marker_valid);
          check_field("marker_value", want.marker_value, got_res.marker_value);
        end
      end
      out_ready <= !idle_now();
    end
  end

  // Stimulus and end of run
  initial begin
    in_t it;

    // Short Jcc: JO taken forward by the largest displacement
    it = rand_instr($urandom, {32'($urandom), 8'h7f, 8'h70});
    it.flags = 12'h800;
    instr_q.push_back(it);
    // JG taken backward from address zero, wraps
    it = rand_instr(32'h0, {32'($urandom), 8'h80, 8'h7f});
    it.flags = 12'h000;
    instr_q.push_back(it);
    // Near JG not taken at the top of the address space
    it = rand_instr(32'hffff_fffe, {32'hffff_ffff, 8'h8f, OP_ESCAPE});
    it.flags = 12'h040;
    instr_q.push_back(it);
    // Near JO taken with the most negative displacement
    it = rand_instr($urandom, {32'h8000_0000, 8'h80, OP_ESCAPE});
    it.flags = 12'hfff;
    instr_q.push_back(it);
    instr_q.push_back(rand_instr(32'h0, {32'($urandom), 8'h80, OP_JMP_SHORT}));
    instr_q.push_back(rand_instr(32'hffff_ffff,
                                 {8'($urandom), 32'h7fff_ffff, OP_JMP_NEAR}));
    // CALL with the stack pointer wrapping below zero
    it = rand_instr(32'hffff_fffc, {8'($urandom), 32'($urandom), OP_CALL_NEAR});
    it.reg_sp = 32'h0;
    instr_q.push_back(it);
    // RET with the stack pointer wrapping above the top
    it = rand_instr($urandom, {40'($urandom), OP_RET});
    it.reg_sp = 32'hffff_fffc;
    instr_q.push_back(it);
    instr_q.push_back(rand_instr($urandom, {32'($urandom), OP_RET, OP_REPZ}));
    instr_q.push_back(rand_instr($urandom, {32'($urandom), 8'h90, OP_REPZ}));
    // Group 5 register forms: CALL EAX, JMP EDI
    instr_q.push_back(rand_instr($urandom, {32'($urandom), 8'hd0, OP_GRP5}));
    instr_q.push_back(rand_instr($urandom, {32'($urandom), 8'he7, OP_GRP5}));
    // Absolute disp32 memory operand, CALL and JMP
    instr_q.push_back(rand_instr($urandom, {32'($urandom), 8'h15, OP_GRP5}));
    instr_q.push_back(rand_instr($urandom, {32'($urandom), 8'h25, OP_GRP5}));
    // SIB form is rejected
    instr_q.push_back(rand_instr($urandom, {32'($urandom), 8'h14, OP_GRP5}));
    // disp8 with negative displacement, disp32 off ESI, disp8 off EBP
    instr_q.push_back(rand_instr($urandom, {24'($urandom), 8'h80, 8'h50, OP_GRP5}));
    instr_q.push_back(rand_instr($urandom, {32'($urandom), 8'ha6, OP_GRP5}));
    instr_q.push_back(rand_instr($urandom, {24'($urandom), 8'h7f, 8'h65, OP_GRP5}));
    // Group 5 sub-opcodes other than CALL and JMP
    instr_q.push_back(rand_instr($urandom, {32'($urandom), 8'h00, OP_GRP5}));
    instr_q.push_back(rand_instr($urandom, {32'($urandom), 8'h38, OP_GRP5}));
    // OUT markers, both opcodes
    instr_q.push_back(rand_instr(32'hffff_ffff, {32'($urandom), 8'hff, OP_OUT_B}));
    instr_q.push_back(rand_instr($urandom, {32'($urandom), 8'h00, OP_OUT_W}));
    // RDTSC with the count at its maximum
    it = rand_instr($urandom, {32'($urandom), OP_RDTSC, OP_ESCAPE});
    it.retired_count = '1;
    instr_q.push_back(it);
    // Unknown escape, unsupported opcode, all-zero and all-one beats
    instr_q.push_back(rand_instr($urandom, {32'($urandom), 8'h05, OP_ESCAPE}));
    instr_q.push_back(rand_instr($urandom, {40'($urandom), 8'h90}));
    instr_q.push_back('0);
    instr_q.push_back('1);

    repeat (NUM_RANDOM) instr_q.push_back(gen_instr());

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (instr_q.size() != 0 || in_valid) @(posedge clk_i);
    while (resolved_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Resolved %0d of %0d instructions checked (%0d unsupported),",
             n_handled, n_checked, n_checked - n_handled);
    $display("%0d with targets from memory, %0d pushing a return address.",
             n_loads, n_pushes);
    if (n_errors == 0 && n_checked == n_issued) begin
      $display("[x86_control_flow_resolver] OK");
    end else begin
      $display("[x86_control_flow_resolver] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout after %0d cycles, %0d results outstanding",
             cyc_cnt, resolved_q.size());
    $display("[x86_control_flow_resolver] ERROR");
    $finish;
  end

endmodule

[x86_control_flow_resolver.f]
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_decode.sv
hw/rtl/cfr_exec.sv
hw/rtl/cfr_result.sv
hw/rtl/x86_control_flow_resolver.sv
tb/x86_control_flow_resolver_test.sv
